FILE: src/vmo_pkg.sv
// Shared constants and types for the view matrix orthonormalizer.
package vmo_pkg;

  localparam int DATA_W    = 32;
  localparam int AXIS_FRAC = 30;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ROOT_W    = PROD_W / 2;
  localparam int QUO_W     = 32;
  localparam int FRONT_LAT = 8;
  localparam int NORM_LAT  = FRONT_LAT + ROOT_W + 1 + QUO_W + 1;
  localparam int TOT_LAT   = 3 * NORM_LAT + 7;

  typedef logic [PROD_W-1:0] wide_t;
  typedef wide_t [2:0]       wvec_t;
  typedef logic [DATA_W-1:0] axis_t;
  typedef axis_t [2:0]       avec_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] look_x;
    logic signed [DATA_W-1:0] look_y;
    logic signed [DATA_W-1:0] look_z;
    logic signed [DATA_W-1:0] side_x;
    logic signed [DATA_W-1:0] side_y;
    logic signed [DATA_W-1:0] side_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] axis_right_x;
    logic signed [DATA_W-1:0] axis_right_y;
    logic signed [DATA_W-1:0] axis_right_z;
    logic signed [DATA_W-1:0] axis_up_x;
    logic signed [DATA_W-1:0] axis_up_y;
    logic signed [DATA_W-1:0] axis_up_z;
    logic signed [DATA_W-1:0] axis_look_x;
    logic signed [DATA_W-1:0] axis_look_y;
    logic signed [DATA_W-1:0] axis_look_z;
    logic signed [DATA_W-1:0] trans_x;
    logic signed [DATA_W-1:0] trans_y;
    logic signed [DATA_W-1:0] trans_z;
  } out_t;

endpackage

FILE: src/view_matrix_orthonormalize_top.sv
// Top level of the look-at view matrix orthonormalizer.
// One item is taken in every cycle (busy stays low) and its result strobes
// out_valid after three normalizers of 74 stages each (scaling, square sum,
// a 32-stage square root, a 32-stage divider) plus two cross-product stages
// after each of the first two and three translation stages at the end.
// Results appear in input order and cannot be held off.
module view_matrix_orthonormalize_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  vmo_pkg::in_t  in_data,
  output logic          out_valid,
  output vmo_pkg::out_t out_data
);

  localparam int NL = vmo_pkg::NORM_LAT;
  localparam int PW = vmo_pkg::PROD_W;
  localparam int DW = vmo_pkg::DATA_W;

  function automatic vmo_pkg::axis_t sat_trans(vmo_pkg::wide_t d);
    vmo_pkg::wide_t n;
    vmo_pkg::wide_t m;
    vmo_pkg::wide_t q;
    vmo_pkg::wide_t lim_neg;
    vmo_pkg::wide_t t;
    lim_neg = PW'(1) << (DW - 1);
    n = PW'(0) - d;
    m = n[PW-1] ? (PW'(0) - n) : n;
    q = (m + (PW'(1) << (vmo_pkg::AXIS_FRAC - 1))) >> vmo_pkg::AXIS_FRAC;
    if (n[PW-1]) begin
      if (q > lim_neg) q = lim_neg;
      t = PW'(0) - q;
    end else begin
      if (q > lim_neg - PW'(1)) q = lim_neg - PW'(1);
      t = q;
    end
    return t[DW-1:0];
  endfunction

  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // input vectors
  vmo_pkg::wvec_t lk_in;
  vmo_pkg::avec_t sd_in;
  vmo_pkg::avec_t pos_in;

  assign lk_in[0] = {{DW{in_data.look_x[DW-1]}}, in_data.look_x};
  assign lk_in[1] = {{DW{in_data.look_y[DW-1]}}, in_data.look_y};
  assign lk_in[2] = {{DW{in_data.look_z[DW-1]}}, in_data.look_z};
  assign sd_in    = {in_data.side_z, in_data.side_y, in_data.side_x};
  assign pos_in   = {in_data.pos_z, in_data.pos_y, in_data.pos_x};

  // delay lines that keep operands aligned with the normalizers
  vmo_pkg::avec_t sd_dly_r  [NL];
  vmo_pkg::avec_t pos_dly_r [3*NL+4];
  vmo_pkg::avec_t lk_dly_r  [2*NL+6];
  vmo_pkg::avec_t up_dly_r  [NL+4];
  vmo_pkg::avec_t rt_dly_r  [2];
  vmo_pkg::avec_t look_ax;
  vmo_pkg::avec_t up_ax;
  vmo_pkg::avec_t rt_ax;

  always_ff @(posedge clk) begin
    sd_dly_r[0]  <= sd_in;
    pos_dly_r[0] <= pos_in;
    lk_dly_r[0]  <= look_ax;
    up_dly_r[0]  <= up_ax;
    rt_dly_r[0]  <= rt_ax;
    for (int k = 1; k < NL; k++) sd_dly_r[k] <= sd_dly_r[k-1];
    for (int k = 1; k < 3*NL+4; k++) pos_dly_r[k] <= pos_dly_r[k-1];
    for (int k = 1; k < 2*NL+6; k++) lk_dly_r[k] <= lk_dly_r[k-1];
    for (int k = 1; k < NL+4; k++) up_dly_r[k] <= up_dly_r[k-1];
    rt_dly_r[1] <= rt_dly_r[0];
  end

  // normalize look
  logic n1_vld;

  vmo_norm u_norm_look (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_xfer),
    .in_vec  (lk_in),
    .out_vld (n1_vld),
    .out_vec (look_ax)
  );

  // up before normalizing: look x side, products then differences
  vmo_pkg::wide_t [5:0] cp1_r;
  vmo_pkg::wvec_t       cr1_r;
  vmo_pkg::avec_t       sd_a;
  logic [1:0]           x1v_r;

  assign sd_a = sd_dly_r[NL-1];

  always_ff @(posedge clk) begin
    cp1_r[0] <= $signed(look_ax[1]) * $signed(sd_a[2]);
    cp1_r[1] <= $signed(look_ax[2]) * $signed(sd_a[1]);
    cp1_r[2] <= $signed(look_ax[2]) * $signed(sd_a[0]);
    cp1_r[3] <= $signed(look_ax[0]) * $signed(sd_a[2]);
    cp1_r[4] <= $signed(look_ax[0]) * $signed(sd_a[1]);
    cp1_r[5] <= $signed(look_ax[1]) * $signed(sd_a[0]);
    cr1_r[0] <= cp1_r[0] - cp1_r[1];
    cr1_r[1] <= cp1_r[2] - cp1_r[3];
    cr1_r[2] <= cp1_r[4] - cp1_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1v_r <= '0;
    end else begin
      x1v_r <= {x1v_r[0], n1_vld};
    end
  end

  logic n2_vld;

  vmo_norm u_norm_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (x1v_r[1]),
    .in_vec  (cr1_r),
    .out_vld (n2_vld),
    .out_vec (up_ax)
  );

  // right before normalizing: up x look
  vmo_pkg::wide_t [5:0] cp2_r;
  vmo_pkg::wvec_t       cr2_r;
  vmo_pkg::avec_t       lk_a;
  logic [1:0]           x2v_r;

  assign lk_a = lk_dly_r[NL+1];

  always_ff @(posedge clk) begin
    cp2_r[0] <= $signed(up_ax[1]) * $signed(lk_a[2]);
    cp2_r[1] <= $signed(up_ax[2]) * $signed(lk_a[1]);
    cp2_r[2] <= $signed(up_ax[2]) * $signed(lk_a[0]);
    cp2_r[3] <= $signed(up_ax[0]) * $signed(lk_a[2]);
    cp2_r[4] <= $signed(up_ax[0]) * $signed(lk_a[1]);
    cp2_r[5] <= $signed(up_ax[1]) * $signed(lk_a[0]);
    cr2_r[0] <= cp2_r[0] - cp2_r[1];
    cr2_r[1] <= cp2_r[2] - cp2_r[3];
    cr2_r[2] <= cp2_r[4] - cp2_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2v_r <= '0;
    end else begin
      x2v_r <= {x2v_r[0], n2_vld};
    end
  end

  logic n3_vld;

  vmo_norm u_norm_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (x2v_r[1]),
    .in_vec  (cr2_r),
    .out_vld (n3_vld),
    .out_vec (rt_ax)
  );

  // translations: products, dot sums, negate, round and saturate
  vmo_pkg::wide_t [2:0][2:0] tp_r;
  vmo_pkg::wvec_t            ts_r;
  vmo_pkg::avec_t            pos_a;
  vmo_pkg::avec_t            up_a;
  vmo_pkg::avec_t            lk_b;
  logic [2:0]                tv_r;
  vmo_pkg::out_t             out_r;

  assign pos_a = pos_dly_r[3*NL+3];
  assign up_a  = up_dly_r[NL+1];
  assign lk_b  = lk_dly_r[2*NL+3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      tp_r[0][k] <= $signed(pos_a[k]) * $signed(rt_ax[k]);
      tp_r[1][k] <= $signed(pos_a[k]) * $signed(up_a[k]);
      tp_r[2][k] <= $signed(pos_a[k]) * $signed(lk_b[k]);
    end
    for (int a = 0; a < 3; a++) begin
      ts_r[a] <= tp_r[a][0] + tp_r[a][1] + tp_r[a][2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    out_r.axis_right_x <= rt_dly_r[1][0];
    out_r.axis_right_y <= rt_dly_r[1][1];
    out_r.axis_right_z <= rt_dly_r[1][2];
    out_r.axis_up_x    <= up_dly_r[NL+3][0];
    out_r.axis_up_y    <= up_dly_r[NL+3][1];
    out_r.axis_up_z    <= up_dly_r[NL+3][2];
    out_r.axis_look_x  <= lk_dly_r[2*NL+5][0];
    out_r.axis_look_y  <= lk_dly_r[2*NL+5][1];
    out_r.axis_look_z  <= lk_dly_r[2*NL+5][2];
    out_r.trans_x      <= sat_trans(ts_r[0]);
    out_r.trans_y      <= sat_trans(ts_r[1]);
    out_r.trans_z      <= sat_trans(ts_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
    end else begin
      tv_r <= {tv_r[1:0], n3_vld};
    end
  end

  assign out_valid = tv_r[2];
  assign out_data  = out_r;

  // every result traces back to a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, vmo_pkg::TOT_LAT))
    else $error("result without matching input transfer");

  // x components of the normalized axes stay within unit range
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.axis_look_x <= 32'sd1073741824)
      && (out_data.axis_look_x >= -32'sd1073741824)
      && (out_data.axis_up_x <= 32'sd1073741824)
      && (out_data.axis_up_x >= -32'sd1073741824)
      && (out_data.axis_right_x <= 32'sd1073741824)
      && (out_data.axis_right_x >= -32'sd1073741824))
    else $error("axis component outside unit range");

  // a zero look collapses the whole frame
  a_zero_look: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_look_x == 0 && out_data.axis_look_y == 0
      && out_data.axis_look_z == 0
    |-> out_data.axis_up_x == 0 && out_data.axis_up_y == 0 && out_data.axis_up_z == 0
      && out_data.axis_right_x == 0 && out_data.axis_right_y == 0
      && out_data.axis_right_z == 0)
    else $error("zero look did not give zero axes");

  // a zero up axis gives a zero right axis and zero x and y translations
  a_zero_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_up_x == 0 && out_data.axis_up_y == 0
      && out_data.axis_up_z == 0
    |-> out_data.axis_right_x == 0 && out_data.axis_right_y == 0
      && out_data.axis_right_z == 0 && out_data.trans_x == 0 && out_data.trans_y == 0)
    else $error("zero up did not give zero right axis");

endmodule

FILE: src/vmo_norm.sv
// Pipelined 3-vector normalizer: scale, square sum, square root, divide, sign.
module vmo_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  vmo_pkg::wvec_t in_vec,
  output logic           out_vld,
  output vmo_pkg::avec_t out_vec
);

  localparam int PW = vmo_pkg::PROD_W;
  localparam int RW = vmo_pkg::ROOT_W;
  localparam int QW = vmo_pkg::QUO_W;
  localparam int NL = vmo_pkg::NORM_LAT;
  localparam int SW = RW + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } ctl_t;

  typedef logic [RW-1:0] mag_t;
  typedef mag_t [2:0]    mvec_t;

  // valid bits travel alongside the data
  logic [NL-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NL-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[NL-1];

  // stage 1: magnitudes and signs
  vmo_pkg::wvec_t m1_r;
  logic [2:0]     neg1_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      neg1_r[k] <= in_vec[k][PW-1];
      m1_r[k]   <= in_vec[k][PW-1] ? (PW'(0) - in_vec[k]) : in_vec[k];
    end
  end

  // stage 2: largest magnitude
  vmo_pkg::wvec_t m2_r;
  vmo_pkg::wide_t mx2_r;
  logic [2:0]     neg2_r;
  vmo_pkg::wide_t mx_c;

  always_comb begin
    mx_c = m1_r[0];
    if (m1_r[1] > mx_c) mx_c = m1_r[1];
    if (m1_r[2] > mx_c) mx_c = m1_r[2];
  end

  always_ff @(posedge clk) begin
    m2_r   <= m1_r;
    mx2_r  <= mx_c;
    neg2_r <= neg1_r;
  end

  // stage 3: leading one inside each byte
  vmo_pkg::wvec_t  m3_r;
  vmo_pkg::wide_t  mx3_r;
  logic [2:0]      neg3_r;
  logic [7:0]      nz3_r;
  logic [7:0][2:0] hb3_r;
  logic [7:0]      nz_c;
  logic [7:0][2:0] hb_c;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_c[g] = |mx2_r[8*g +: 8];
      hb_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mx2_r[8*g+b]) hb_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    m3_r   <= m2_r;
    mx3_r  <= mx2_r;
    neg3_r <= neg2_r;
    nz3_r  <= nz_c;
    hb3_r  <= hb_c;
  end

  // stage 4: leading one of the whole word
  vmo_pkg::wvec_t m4_r;
  vmo_pkg::wide_t mx4_r;
  logic [5:0]     p4_r;
  ctl_t           ctl4_r;
  logic [5:0]     p_c;

  always_comb begin
    p_c = '0;
    for (int g = 0; g < 8; g++) begin
      if (nz3_r[g]) p_c = {3'(g), hb3_r[g]};
    end
  end

  always_ff @(posedge clk) begin
    m4_r        <= m3_r;
    mx4_r       <= mx3_r;
    p4_r        <= p_c;
    ctl4_r.neg  <= neg3_r;
    ctl4_r.zero <= ~|nz3_r;
  end

  // stage 5: bring the largest magnitude near [2^30, 2^32)
  logic [2:0][SW-1:0] ms5_r;
  logic [SW-1:0]      mxs5_r;
  logic               big5_r;
  ctl_t               ctl5_r;
  logic               big_c;
  logic [5:0]         rsh_c;
  logic [5:0]         lsh_c;
  vmo_pkg::wvec_t     ms_c;
  vmo_pkg::wide_t     mxs_c;

  always_comb begin
    big_c = p4_r > 6'd30;
    rsh_c = p4_r - 6'd31;
    lsh_c = 6'd30 - p4_r;
    for (int k = 0; k < 3; k++) begin
      ms_c[k] = big_c ? (m4_r[k] >> rsh_c) : (m4_r[k] << lsh_c);
    end
    mxs_c = big_c ? (mx4_r >> rsh_c) : (mx4_r << lsh_c);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ms5_r[k] <= ms_c[k][SW-1:0];
    end
    mxs5_r <= mxs_c[SW-1:0];
    big5_r <= big_c;
    ctl5_r <= ctl4_r;
  end

  // stage 6: one more right step after a right shift, unless the largest sits exactly at 2^31
  mvec_t mn6_r;
  ctl_t  ctl6_r;
  logic  adj_c;

  assign adj_c = big5_r && (mxs5_r != (SW'(1) << (RW-1)));

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mn6_r[k] <= adj_c ? ms5_r[k][SW-1:1] : ms5_r[k][RW-1:0];
    end
    ctl6_r <= ctl5_r;
  end

  // stage 7: squares
  vmo_pkg::wvec_t sq7_r;
  mvec_t          mn7_r;
  ctl_t           ctl7_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq7_r[k] <= PW'(mn6_r[k]) * PW'(mn6_r[k]);
    end
    mn7_r  <= mn6_r;
    ctl7_r <= ctl6_r;
  end

  // stage 8 and square root stages: one root bit per stage
  vmo_pkg::wide_t sq_rem_r  [RW+1];
  mag_t           sq_root_r [RW+1];
  mvec_t          sq_mn_r   [RW+1];
  ctl_t           sq_ctl_r  [RW+1];

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= sq7_r[0] + sq7_r[1] + sq7_r[2];
    sq_root_r[0] <= '0;
    sq_mn_r[0]   <= mn7_r;
    sq_ctl_r[0]  <= ctl7_r;
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int I = RW - 1 - j;
    logic [PW+1:0] trial;
    logic          take;

    assign trial = ((PW+2)'(sq_root_r[j]) << (I + 1)) | ((PW+2)'(1) << (2 * I));
    assign take  = (PW+2)'(sq_rem_r[j]) >= trial;

    always_ff @(posedge clk) begin
      sq_rem_r[j+1]  <= take ? (sq_rem_r[j] - trial[PW-1:0]) : sq_rem_r[j];
      sq_root_r[j+1] <= take ? (sq_root_r[j] | (RW'(1) << I)) : sq_root_r[j];
      sq_mn_r[j+1]   <= sq_mn_r[j];
      sq_ctl_r[j+1]  <= sq_ctl_r[j];
    end
  end

  // numerator stage and restoring divide stages: one quotient bit per stage
  vmo_pkg::wvec_t dv_rem_r [QW+1];
  logic [2:0][QW-1:0] dv_q_r [QW+1];
  mag_t           dv_div_r [QW+1];
  ctl_t           dv_ctl_r [QW+1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dv_rem_r[0][k] <= (PW'(sq_mn_r[RW][k]) << vmo_pkg::AXIS_FRAC)
                        + PW'(sq_root_r[RW] >> 1);
    end
    dv_q_r[0]   <= '0;
    dv_div_r[0] <= sq_root_r[RW];
    dv_ctl_r[0] <= sq_ctl_r[RW];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int I = QW - 1 - j;
    vmo_pkg::wide_t dsr;

    assign dsr = PW'(dv_div_r[j]) << I;

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_rem_r[j][k] >= dsr) begin
          dv_rem_r[j+1][k] <= dv_rem_r[j][k] - dsr;
          dv_q_r[j+1][k]   <= dv_q_r[j][k] | (QW'(1) << I);
        end else begin
          dv_rem_r[j+1][k] <= dv_rem_r[j][k];
          dv_q_r[j+1][k]   <= dv_q_r[j][k];
        end
      end
      dv_div_r[j+1] <= dv_div_r[j];
      dv_ctl_r[j+1] <= dv_ctl_r[j];
    end
  end

  // apply sign, force zero vectors to zero
  vmo_pkg::avec_t out_vec_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (dv_ctl_r[QW].zero) begin
        out_vec_r[k] <= '0;
      end else if (dv_ctl_r[QW].neg[k]) begin
        out_vec_r[k] <= vmo_pkg::DATA_W'(0) - vmo_pkg::DATA_W'(dv_q_r[QW][k]);
      end else begin
        out_vec_r[k] <= vmo_pkg::DATA_W'(dv_q_r[QW][k]);
      end
    end
  end

  assign out_vec = out_vec_r;

endmodule
